// ===== hdl/assert_macros.svh =====
// Assertion helpers for the burst onset detector.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define BOD_ASSERT(name, clk_sig, rst_sig, prop) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed");

// A condition that must never be true outside reset.
`define BOD_NEVER(name, clk_sig, rst_sig, cond) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BOD_ASSERT(name, clk_sig, rst_sig, prop)
`define BOD_NEVER(name, clk_sig, rst_sig, cond)

`endif

`endif

// ===== hdl/bod_pkg.sv =====
`default_nettype none

package bod_pkg;

  localparam int SAMPLE_W   = 24;  // sample and magnitude width
  localparam int IDX_W      = 20;  // sample counter width
  localparam int FILL_W     = 17;  // holds a window length up to 65536
  localparam int LEN_W      = 20;  // width used to clamp the window length
  localparam int START_W    = 25;  // first start plus slot times period
  localparam int SLOT_OUT_W = 3;
  localparam int ONSET_W    = 21;
  localparam int REL_W      = 16;
  localparam int PROD_W     = SAMPLE_W + REL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [IDX_W-1:0]   COUNTER_MAX = '1;
  localparam logic [ONSET_W-1:0] ONSET_NONE  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_START,
    REG_PERIOD,
    REG_LENGTH,
    REG_REL,
    REG_MIN
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_OPEN,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_THR,
    BK_SCAN,
    BK_EMIT,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]    first_start;
    logic [IDX_W-1:0]    period;
    logic [FILL_W-1:0]   length;
    logic [REL_W-1:0]    rel;
    logic [SAMPLE_W-1:0] min_thr;
  } cfg_t;

  // One unit of back-end work: an optional closed window to scan, then an
  // optional run of empty results up to the last slot.
  typedef struct packed {
    logic                  has_window;
    logic                  flush;
    logic [SLOT_OUT_W-1:0] slot;
    logic [IDX_W-1:0]      base;
    logic [FILL_W-1:0]     fill;
    logic [SAMPLE_W-1:0]   peak;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/bod_ram.sv =====
`default_nettype none

module bod_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/bod_front.sv =====
`default_nettype none
`include "assert_macros.svh"

module bod_front #(
  parameter int WINDOW_DEPTH = 65536,
  parameter int BURST_SLOTS  = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bod_pkg::cfg_t                       cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [bod_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                                last_sample,
  input  wire logic                                back_busy,
  input  wire logic                                job_full,
  output logic                                     job_push,
  output bod_pkg::job_t                            job,
  output logic                                     ram_we,
  output logic [$clog2(WINDOW_DEPTH)-1:0]          ram_waddr,
  output logic [bod_pkg::SAMPLE_W-1:0]             ram_wdata
);

  localparam int SLOT_W   = $clog2(BURST_SLOTS + 1);
  localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W = bod_pkg::SAMPLE_W;
  localparam int IDX_W    = bod_pkg::IDX_W;
  localparam int FILL_W   = bod_pkg::FILL_W;
  localparam int LEN_W    = bod_pkg::LEN_W;
  localparam int START_W  = bod_pkg::START_W;
  localparam int SLOT_O_W = bod_pkg::SLOT_OUT_W;
  localparam logic [SLOT_W-1:0] NUM_SLOTS = SLOT_W'(BURST_SLOTS);
  localparam logic [LEN_W-1:0]  DEPTH_LEN = LEN_W'(WINDOW_DEPTH);

  bod_pkg::phase_t     phase, phase_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic [IDX_W-1:0]    counter, counter_next;
  logic [IDX_W-1:0]    base, base_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [SAMPLE_W-1:0] peak, peak_next;

  logic [IDX_W-1:0]    per0;
  logic [LEN_W-1:0]    eff_len;
  logic [START_W-1:0]  start;
  logic                opening, open_now, closing, finish, has_window, flush, accept;
  logic [FILL_W-1:0]   fill_cur, fill_new;
  logic [IDX_W-1:0]    base_cur;
  logic [SAMPLE_W-1:0] peak_cur, peak_new, mag;
  logic [SLOT_W-1:0]   slot_w;

  // A period of zero behaves as one.
  assign per0 = (cfg.period == '0) ? IDX_W'(1) : cfg.period;

  always_comb begin
    eff_len = LEN_W'(cfg.length);
    if (eff_len > LEN_W'(per0)) begin
      eff_len = LEN_W'(per0);
    end
    if (eff_len > DEPTH_LEN) begin
      eff_len = DEPTH_LEN;
    end
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end
  end

  assign start = START_W'(cfg.first_start) + START_W'(per0) * START_W'(slot);

  assign opening  = (phase == bod_pkg::PH_WAIT) && (slot < NUM_SLOTS) &&
                    (START_W'(counter) >= start);
  assign open_now = (phase == bod_pkg::PH_OPEN) || opening;
  assign fill_cur = opening ? '0 : fill;
  assign base_cur = opening ? counter : base;
  assign peak_cur = opening ? '0 : peak;

  // Magnitude after sign extension: the most negative code maps to 2^23.
  assign mag      = sample_value[SAMPLE_W-1] ? SAMPLE_W'(-sample_value)
                                             : SAMPLE_W'(sample_value);
  assign peak_new = (mag > peak_cur) ? mag : peak_cur;
  assign fill_new = fill_cur + 1'b1;

  assign closing    = open_now && (LEN_W'(fill_new) >= eff_len);
  assign finish     = last_sample || (counter == bod_pkg::COUNTER_MAX);
  assign has_window = closing || (finish && open_now);
  assign slot_w     = has_window ? slot + 1'b1 : slot;
  assign flush      = finish && (slot_w < NUM_SLOTS);
  assign accept     = in_valid && in_ready;

  // Next state.
  always_comb begin
    phase_next   = phase;
    slot_next    = slot;
    counter_next = counter;
    base_next    = base;
    fill_next    = fill;
    peak_next    = peak;
    if (accept) begin
      base_next = base_cur;
      if (last_sample) begin
        phase_next   = bod_pkg::PH_WAIT;
        slot_next    = '0;
        counter_next = '0;
        fill_next    = '0;
        peak_next    = '0;
      end else if (counter == bod_pkg::COUNTER_MAX) begin
        // Counter has run out: the run is over until a last sample arrives.
        phase_next = bod_pkg::PH_IDLE;
        slot_next  = NUM_SLOTS;
        fill_next  = '0;
        peak_next  = '0;
      end else begin
        if (closing) begin
          slot_next  = slot_w;
          phase_next = (slot_w < NUM_SLOTS) ? bod_pkg::PH_WAIT : bod_pkg::PH_IDLE;
          fill_next  = '0;
          peak_next  = '0;
        end else if (open_now) begin
          phase_next = bod_pkg::PH_OPEN;
          fill_next  = fill_new;
          peak_next  = peak_new;
        end
        if (phase_next != bod_pkg::PH_IDLE) begin
          counter_next = counter + 1'b1;
        end
      end
    end
  end

  // Outputs. A sample that lands in a window waits until the back end is
  // idle and the job queue is empty; any sample waits while the queue is full.
  always_comb begin
    in_ready       = !job_full && !(open_now && back_busy);
    job_push       = accept && (has_window || flush);
    job.has_window = has_window;
    job.flush      = flush;
    job.slot       = SLOT_O_W'(slot);
    job.base       = base_cur;
    job.fill       = fill_new;
    job.peak       = peak_new;
    ram_we         = accept && open_now;
    ram_waddr      = ADDR_W'(fill_cur);
    ram_wdata      = mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= bod_pkg::PH_WAIT;
      slot    <= '0;
      counter <= '0;
      fill    <= '0;
      peak    <= '0;
      base    <= '0;
    end else begin
      phase   <= phase_next;
      slot    <= slot_next;
      counter <= counter_next;
      fill    <= fill_next;
      peak    <= peak_next;
      base    <= base_next;
    end
  end

  `BOD_NEVER(a_write_during_scan, clk, rst, ram_we && back_busy)
  `BOD_NEVER(a_push_when_full, clk, rst, job_push && job_full)

endmodule

`default_nettype wire

// ===== hdl/bod_job_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

module bod_job_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bod_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output bod_pkg::job_t      pop_data,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  bod_pkg::job_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BOD_NEVER(a_pop_when_empty, clk, rst, pop && empty)

endmodule

`default_nettype wire

// ===== hdl/bod_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module bod_back #(
  parameter int WINDOW_DEPTH = 65536,
  parameter int BURST_SLOTS  = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bod_pkg::cfg_t                       cfg,
  input  wire logic                                job_empty,
  input  wire bod_pkg::job_t                       job_data,
  output logic                                     job_pop,
  output logic                                     busy,
  output logic [$clog2(WINDOW_DEPTH)-1:0]          ram_raddr,
  input  wire logic [bod_pkg::SAMPLE_W-1:0]        ram_rdata,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [bod_pkg::SLOT_OUT_W-1:0]           out_slot,
  output logic [bod_pkg::ONSET_W-1:0]              out_onset,
  output logic                                     out_last
);

  localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W = bod_pkg::SAMPLE_W;
  localparam int FILL_W   = bod_pkg::FILL_W;
  localparam int SLOT_O_W = bod_pkg::SLOT_OUT_W;
  localparam int ONSET_W  = bod_pkg::ONSET_W;
  localparam int PROD_W   = bod_pkg::PROD_W;
  localparam int REL_W    = bod_pkg::REL_W;
  localparam logic [SLOT_O_W-1:0] LAST_SLOT = SLOT_O_W'(BURST_SLOTS - 1);

  bod_pkg::back_state_t state, state_next;
  bod_pkg::job_t        job;
  logic [PROD_W-1:0]    prod;
  logic [SAMPLE_W-1:0]  thr, rel_thr;
  logic [FILL_W-1:0]    issue_idx, pend_idx;
  logic                 pend;
  logic [ONSET_W-1:0]   onset;
  logic [SLOT_O_W-1:0]  fslot;
  logic                 out_free, issue, hit, scan_done, load;

  assign out_free = !out_valid || out_ready;
  assign rel_thr  = prod[PROD_W-1:REL_W];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bod_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_next = job_data.has_window ? bod_pkg::BK_MUL : bod_pkg::BK_FLUSH;
        end
      end
      bod_pkg::BK_MUL: begin
        state_next = (job.peak < cfg.min_thr) ? bod_pkg::BK_EMIT : bod_pkg::BK_THR;
      end
      bod_pkg::BK_THR: begin
        state_next = bod_pkg::BK_SCAN;
      end
      bod_pkg::BK_SCAN: begin
        if (hit || scan_done) begin
          state_next = bod_pkg::BK_EMIT;
        end
      end
      bod_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = job.flush ? bod_pkg::BK_FLUSH : bod_pkg::BK_IDLE;
        end
      end
      bod_pkg::BK_FLUSH: begin
        if (out_free && (fslot == LAST_SLOT)) begin
          state_next = bod_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = bod_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer. Buffer data arrives in the cycle after its
  // address, so pend marks that ram_rdata belongs to entry pend_idx.
  always_comb begin
    job_pop   = (state == bod_pkg::BK_IDLE) && !job_empty;
    busy      = (state != bod_pkg::BK_IDLE);
    issue     = (state == bod_pkg::BK_SCAN) && (issue_idx < job.fill);
    hit       = (state == bod_pkg::BK_SCAN) && pend && (ram_rdata >= thr);
    scan_done = (state == bod_pkg::BK_SCAN) && !pend && !(issue_idx < job.fill);
    ram_raddr = ADDR_W'(issue_idx);
    load      = out_free && ((state == bod_pkg::BK_EMIT) || (state == bod_pkg::BK_FLUSH));
  end

  always_ff @(posedge clk) begin
    case (state)
      bod_pkg::BK_IDLE: begin
        if (job_pop) begin
          job   <= job_data;
          fslot <= job_data.slot;
        end
      end
      bod_pkg::BK_MUL: begin
        prod  <= PROD_W'(job.peak) * PROD_W'(cfg.rel);
        onset <= bod_pkg::ONSET_NONE;
      end
      bod_pkg::BK_THR: begin
        thr       <= (rel_thr > cfg.min_thr) ? rel_thr : cfg.min_thr;
        issue_idx <= '0;
        pend      <= 1'b0;
      end
      bod_pkg::BK_SCAN: begin
        pend <= issue;
        if (issue) begin
          issue_idx <= issue_idx + 1'b1;
          pend_idx  <= issue_idx;
        end
        if (hit) begin
          onset <= ONSET_W'(job.base) + ONSET_W'(pend_idx);
        end
      end
      bod_pkg::BK_EMIT: begin
        if (out_free) begin
          fslot <= job.slot + 1'b1;
        end
      end
      bod_pkg::BK_FLUSH: begin
        if (out_free) begin
          fslot <= fslot + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: the next result can be prepared while this one waits.
  always_ff @(posedge clk) begin
    if (load) begin
      if (state == bod_pkg::BK_EMIT) begin
        out_slot  <= job.slot;
        out_onset <= onset;
        out_last  <= (job.slot == LAST_SLOT);
      end else begin
        out_slot  <= fslot;
        out_onset <= bod_pkg::ONSET_NONE;
        out_last  <= (fslot == LAST_SLOT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bod_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BOD_ASSERT(a_read_in_window, clk, rst, (state == bod_pkg::BK_SCAN && pend) |-> (pend_idx < job.fill))

endmodule

`default_nettype wire

// ===== hdl/burst_onset_detector_unit.sv =====
`default_nettype none
// Burst onset detector.
// Input stream (s_*): one signed Q1.23 audio sample per word in s_tdata,
// s_tlast marks the final sample of a capture. Samples are numbered from 0.
// Output stream (m_*): one word per search window, burst slot and onset
// index (or all ones when no burst was found); m_tlast marks the result
// for the last slot. Configuration is written through cfg_we/cfg_index/
// cfg_wdata while the block has no work outstanding.
// Samples outside a window, and samples inside a window while the buffer
// is free, are taken at one per cycle while the job queue has room. When a
// window closes its scan runs in the back end: it forms the product, and
// unless the peak is below the floor it forms the threshold and reads one
// buffer entry per cycle through the single read port of the window buffer
// until the first hit or the end; then it loads the result register. A
// sample that falls in the next window waits until the back end is idle
// and the job queue is empty. Empty results for remaining slots follow at
// one per cycle while m_tready is high.
// Reset clears the counters, the queue and the result valid flag and loads
// the default configuration; the window buffer is not cleared. While
// m_tready is low one result is held and at most two further jobs queue.
module burst_onset_detector_unit #(
  parameter int WINDOW_DEPTH = 65536,
  parameter int BURST_SLOTS  = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [23:0] sample_value
  input  wire logic        s_tlast,   // last_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] burst_slot, [23:3] onset_index
  output logic             m_tlast,   // last_result
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W = bod_pkg::SAMPLE_W;
  localparam int IDX_W    = bod_pkg::IDX_W;
  localparam int FILL_W   = bod_pkg::FILL_W;
  localparam int REL_W    = bod_pkg::REL_W;

  bod_pkg::cfg_t cfg;
  bod_pkg::job_t push_job, pop_job;
  logic          job_push, job_pop, job_full, job_empty, back_busy, busy;
  logic          ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic [bod_pkg::SLOT_OUT_W-1:0] out_slot;
  logic [bod_pkg::ONSET_W-1:0]    out_onset;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_start <= IDX_W'(42720);
      cfg.period      <= IDX_W'(48000);
      cfg.length      <= FILL_W'(14880);
      cfg.rel         <= REL_W'(6554);
      cfg.min_thr     <= SAMPLE_W'(839);
    end else if (cfg_we) begin
      case (bod_pkg::reg_index_t'(cfg_index))
        bod_pkg::REG_FIRST_START: cfg.first_start <= cfg_wdata[IDX_W-1:0];
        bod_pkg::REG_PERIOD:      cfg.period      <= cfg_wdata[IDX_W-1:0];
        bod_pkg::REG_LENGTH:      cfg.length      <= cfg_wdata[FILL_W-1:0];
        bod_pkg::REG_REL:         cfg.rel         <= cfg_wdata[REL_W-1:0];
        bod_pkg::REG_MIN:         cfg.min_thr     <= cfg_wdata[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign back_busy = busy || !job_empty;

  bod_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .BURST_SLOTS (BURST_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample_value(s_tdata),
    .last_sample (s_tlast),
    .back_busy   (back_busy),
    .job_full    (job_full),
    .job_push    (job_push),
    .job         (push_job),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  bod_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bod_job_fifo #(
    .DEPTH(2)
  ) u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(push_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_data (pop_job),
    .empty    (job_empty)
  );

  bod_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .BURST_SLOTS (BURST_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_empty(job_empty),
    .job_data (pop_job),
    .job_pop  (job_pop),
    .busy     (busy),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_slot (out_slot),
    .out_onset(out_onset),
    .out_last (m_tlast)
  );

  assign m_tdata = {out_onset, out_slot};

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH         = 65536;
  localparam int SLOTS         = 3;
  localparam int RANDOM_WORDS  = 120;
  localparam int MIN_CAPTURES  = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int TAIL_CYCLES   = 64;

  typedef enum logic [1:0] {
    PEND_SAMPLE,
    PEND_CFG,
    PEND_DRAIN
  } pend_kind_t;

  typedef struct packed {
    pend_kind_t          kind;
    logic [23:0]         word;
    logic                is_last;
    bod_pkg::reg_index_t reg_sel;
    logic [23:0]         value;
  } pend_item_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic [20:0] onset;
    logic        is_last;
  } onset_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  pend_item_t pending[$];
  onset_rec_t onsets_due[$];
  int         mismatches = 0;
  int         results_seen = 0;
  bit         in_taken = 1'b0;

  // Predictor state.
  bod_pkg::cfg_t   live_cfg;
  logic [23:0]     mag_store [0:DEPTH-1];
  logic [19:0]     cnt_now;
  logic [23:0]     peak_now;
  int              slot_now;
  bod_pkg::phase_t phase_now;
  logic [19:0]     base_now;
  int              fill_now;

  always #6 clk = ~clk;

  burst_onset_detector_unit #(
    .WINDOW_DEPTH(DEPTH),
    .BURST_SLOTS (SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  function automatic void reset_tracker();
    cnt_now = '0;
    peak_now = '0;
    slot_now = 0;
    phase_now = bod_pkg::PH_WAIT;
    base_now = '0;
    fill_now = 0;
    live_cfg.first_start = 20'd42720;
    live_cfg.period = 20'd48000;
    live_cfg.length = 17'd14880;
    live_cfg.rel = 16'd6554;
    live_cfg.min_thr = 24'd839;
  endfunction

  function automatic int window_span();
    int per;
    int len;
    per = (live_cfg.period == 0) ? 1 : int'(live_cfg.period);
    len = int'(live_cfg.length);
    if (len > per) len = per;
    if (len > DEPTH) len = DEPTH;
    if (len == 0) len = 1;
    return len;
  endfunction

  function automatic void emit_onset(int slot, logic [20:0] onset);
    onset_rec_t rec;
    rec.slot = slot[2:0];
    rec.onset = onset;
    rec.is_last = (slot == SLOTS - 1);
    onsets_due.insert(onsets_due.size(), rec);
  endfunction

  // The onset is the index of the first buffered magnitude reaching the larger
  // of the floor and the scaled peak, if the peak reaches the floor.
  function automatic void close_window_now();
    logic [20:0] onset;
    longint      thr;
    int          i;
    bit          found;
    onset = bod_pkg::ONSET_NONE;
    if (peak_now >= live_cfg.min_thr) begin
      thr = (longint'(peak_now) * longint'(live_cfg.rel)) >> 16;
      if (thr < longint'(live_cfg.min_thr)) thr = longint'(live_cfg.min_thr);
      i = 0;
      found = 1'b0;
      while (!found && i < fill_now) begin
        if (longint'(mag_store[i]) >= thr) begin
          onset = 21'(base_now) + 21'(i);
          found = 1'b1;
        end
        i++;
      end
    end
    emit_onset(slot_now, onset);
    slot_now++;
    peak_now = '0;
    fill_now = 0;
    phase_now = (slot_now < SLOTS) ? bod_pkg::PH_WAIT : bod_pkg::PH_IDLE;
  endfunction

  function automatic void finish_capture();
    if (phase_now == bod_pkg::PH_OPEN) close_window_now();
    while (slot_now < SLOTS) begin
      emit_onset(slot_now, bod_pkg::ONSET_NONE);
      slot_now++;
    end
    phase_now = bod_pkg::PH_IDLE;
    peak_now = '0;
    fill_now = 0;
  endfunction

  function automatic void track_sample(logic [23:0] sample, logic fin);
    logic [19:0] idx;
    logic [23:0] mag;
    longint      per;
    idx = cnt_now;
    per = (live_cfg.period == 0) ? 1 : longint'(live_cfg.period);
    if (phase_now == bod_pkg::PH_WAIT && slot_now < SLOTS &&
        longint'(idx) >= longint'(live_cfg.first_start) + longint'(slot_now) * per) begin
      phase_now = bod_pkg::PH_OPEN;
      base_now = idx;
      fill_now = 0;
      peak_now = '0;
    end
    if (phase_now == bod_pkg::PH_OPEN) begin
      mag = sample[23] ? -sample : sample;
      mag_store[fill_now % DEPTH] = mag;
      if (mag > peak_now) peak_now = mag;
      fill_now++;
      if (fill_now >= window_span()) close_window_now();
    end
    if (fin) begin
      finish_capture();
      cnt_now = '0;
      slot_now = 0;
      phase_now = bod_pkg::PH_WAIT;
    end else if (idx == bod_pkg::COUNTER_MAX) begin
      // The counter saturates and the run is flushed until a last word.
      finish_capture();
      cnt_now = bod_pkg::COUNTER_MAX;
    end else if (phase_now != bod_pkg::PH_IDLE || slot_now < SLOTS) begin
      cnt_now = idx + 20'd1;
    end
  endfunction

  function automatic void check_onset();
    onset_rec_t want;
    if (onsets_due.size() == 0) begin
      $display("%0t: result word with nothing expected: slot %0d onset %0d last %0b",
               $time, m_tdata[2:0], $signed(m_tdata[23:3]), m_tlast);
      mismatches++;
    end else begin
      want = onsets_due.pop_front();
      if (m_tdata[2:0] !== want.slot) begin
        $display("%0t: burst slot expected %0d actual %0d", $time, want.slot, m_tdata[2:0]);
        mismatches++;
      end
      if (m_tdata[23:3] !== want.onset) begin
        $display("%0t: onset index expected %0d actual %0d", $time,
                 $signed(want.onset), $signed(m_tdata[23:3]));
        mismatches++;
      end
      if (m_tlast !== want.is_last) begin
        $display("%0t: last flag expected %0b actual %0b", $time, want.is_last, m_tlast);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_tracker();
      in_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bod_pkg::REG_FIRST_START: live_cfg.first_start = cfg_wdata[19:0];
          bod_pkg::REG_PERIOD:      live_cfg.period = cfg_wdata[19:0];
          bod_pkg::REG_LENGTH:      live_cfg.length = cfg_wdata[16:0];
          bod_pkg::REG_REL:         live_cfg.rel = cfg_wdata[15:0];
          bod_pkg::REG_MIN:         live_cfg.min_thr = cfg_wdata;
          default: ;
        endcase
      end
      in_taken = s_tvalid && s_tready;
      if (in_taken) track_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        results_seen++;
        check_onset();
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender side.
  int          tx_gap = 0;
  int          tx_steady = 0;
  int          settle = 0;
  logic        tx_valid_n;
  logic [23:0] tx_data_n;
  logic        tx_last_n;
  logic        tx_we_n;
  logic [2:0]  tx_idx_n;
  logic [23:0] tx_wdata_n;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      cfg_we <= 1'b0;
      cfg_index <= '0;
      cfg_wdata <= '0;
    end else begin
      tx_valid_n = s_tvalid && !in_taken;
      tx_data_n = s_tdata;
      tx_last_n = s_tlast;
      tx_we_n = 1'b0;
      tx_idx_n = cfg_index;
      tx_wdata_n = cfg_wdata;
      if (tx_steady > 0) tx_steady--;
      else if ($urandom_range(0, 49) == 0) tx_steady = $urandom_range(20, 80);
      if (!tx_valid_n) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() > 0) begin
          case (pending[0].kind)
            PEND_SAMPLE: begin
              tx_valid_n = 1'b1;
              tx_data_n = pending[0].word;
              tx_last_n = pending[0].is_last;
              void'(pending.pop_front());
              tx_gap = (tx_steady > 0) ? 0 : idle_gap();
            end
            PEND_CFG: begin
              tx_we_n = 1'b1;
              tx_idx_n = pending[0].reg_sel;
              tx_wdata_n = pending[0].value;
              void'(pending.pop_front());
            end
            default: begin
              // Hold off until every result is out and the block has settled.
              if (onsets_due.size() == 0) settle++;
              else settle = 0;
              if (settle >= SETTLE_CYCLES) begin
                settle = 0;
                void'(pending.pop_front());
              end
            end
          endcase
        end
      end
      s_tvalid <= tx_valid_n;
      s_tdata <= tx_data_n;
      s_tlast <= tx_last_n;
      cfg_we <= tx_we_n;
      cfg_index <= tx_idx_n;
      cfg_wdata <= tx_wdata_n;
    end
  end

  // Receiver side.
  int rx_gap = 0;
  int rx_steady = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_steady > 0) rx_steady--;
      else if ($urandom_range(0, 49) == 0) rx_steady = $urandom_range(20, 80);
      if (!long_hold_done && results_seen >= 20) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap = (rx_steady > 0) ? 0 : idle_gap();
      end
    end
  end

  // Stimulus generation.
  int gen_first = 42720;
  int gen_per = 48000;
  int gen_len = 14880;

  function automatic void push_sample(logic [23:0] word, logic fin);
    pend_item_t it;
    it = '0;
    it.kind = PEND_SAMPLE;
    it.word = word;
    it.is_last = fin;
    pending.insert(pending.size(), it);
  endfunction

  function automatic void push_drain();
    pend_item_t it;
    it = '0;
    it.kind = PEND_DRAIN;
    pending.insert(pending.size(), it);
  endfunction

  function automatic void push_cfg(bod_pkg::reg_index_t sel, logic [23:0] value);
    pend_item_t it;
    it = '0;
    it.kind = PEND_CFG;
    it.reg_sel = sel;
    it.value = value;
    pending.insert(pending.size(), it);
    case (sel)
      bod_pkg::REG_FIRST_START: gen_first = int'(value);
      bod_pkg::REG_PERIOD:      gen_per = int'(value);
      bod_pkg::REG_LENGTH:      gen_len = int'(value);
      default: ;
    endcase
  endfunction

  function automatic void queue_setup(logic [23:0] first, logic [23:0] per,
                                      logic [23:0] len, logic [23:0] rel,
                                      logic [23:0] floor_thr);
    push_drain();
    push_cfg(bod_pkg::REG_FIRST_START, first);
    push_cfg(bod_pkg::REG_PERIOD, per);
    push_cfg(bod_pkg::REG_LENGTH, len);
    push_cfg(bod_pkg::REG_REL, rel);
    push_cfg(bod_pkg::REG_MIN, floor_thr);
  endfunction

  // Mostly short windows close to the start, so that every slot is reached.
  function automatic logic [23:0] setting_value(bod_pkg::reg_index_t sel);
    int r;
    r = $urandom_range(0, 99);
    case (sel)
      bod_pkg::REG_FIRST_START:
        return 24'((r < 90) ? $urandom_range(0, 6) : $urandom_range(0, 20'hFFFFF));
      bod_pkg::REG_PERIOD: return 24'((r < 10) ? 0 : $urandom_range(1, 8));
      bod_pkg::REG_LENGTH: return 24'($urandom_range(0, 10));
      bod_pkg::REG_REL:    return 24'($urandom_range(0, 65535));
      default: begin
        if (r < 70) return 24'($urandom_range(0, 1000));
        if (r < 90) return 24'($urandom_range(0, 4194304));
        return (r < 95) ? 24'h800000 : 24'($urandom_range(0, 8388608));
      end
    endcase
  endfunction

  function automatic logic [23:0] sample_word();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      s = $urandom_range(0, 1200) - 600;
    end else if (r < 85) begin
      s = $urandom_range(0, 8388607);
      if ($urandom_range(0, 1) == 1) s = -s;
    end else begin
      s = $urandom();
    end
    return s[23:0];
  endfunction

  initial begin : stimulus
    int                  per;
    int                  len;
    int                  span;
    int                  n;
    int                  cut;
    int                  words;
    int                  captures;
    bod_pkg::reg_index_t sel;

    // Full-scale words with a relative threshold just under the peak.
    queue_setup(0, 4, 3, 65535, 0);
    push_sample(24'h7FFFFF, 1'b0);
    push_sample(24'h800000, 1'b0);
    push_sample(24'h000000, 1'b0);
    push_sample(24'hFFFFFF, 1'b0);
    push_sample(24'd5, 1'b0);
    push_sample(24'd100, 1'b0);
    push_sample(24'd3, 1'b0);
    push_sample(24'd1, 1'b1);

    // Register extremes: no window opens before the capture ends.
    queue_setup(24'hFFFFF, 24'hFFFFF, 24'h10000, 0, 24'h800000);
    push_sample(24'h123456, 1'b0);
    push_sample(24'hEDCBA9, 1'b0);
    push_sample(24'h0F0F0F, 1'b1);

    // Zero period and zero length act as one; words after the final window
    // are ignored. Only -1.0 reaches the top floor.
    queue_setup(0, 0, 0, 32768, 24'h800000);
    push_sample(24'h800000, 1'b0);
    push_sample(24'd7, 1'b0);
    push_sample(24'd100, 1'b0);
    push_sample(24'd55, 1'b0);
    push_sample(24'd66, 1'b1);

    // Length clamped to the period, then a window start already passed,
    // then a length cut below what the open window holds.
    queue_setup(2, 3, 10, 16384, 1);
    push_sample(24'd0, 1'b0);
    push_sample(24'd0, 1'b0);
    push_sample(24'd50, 1'b0);
    push_sample(24'd200, 1'b0);
    push_sample(24'd10, 1'b0);
    push_drain();
    push_cfg(bod_pkg::REG_FIRST_START, 0);
    push_cfg(bod_pkg::REG_LENGTH, 5);
    push_sample(24'd9, 1'b0);
    push_sample(24'd1000, 1'b0);
    push_drain();
    push_cfg(bod_pkg::REG_LENGTH, 1);
    push_sample(24'd3, 1'b0);
    push_sample(24'd4000, 1'b0);
    push_sample(24'd8, 1'b1);

    words = 0;
    captures = 0;
    while (words < RANDOM_WORDS || captures < MIN_CAPTURES) begin
      if (captures == 0 || $urandom_range(0, 2) == 0)
        queue_setup(setting_value(bod_pkg::REG_FIRST_START),
                    setting_value(bod_pkg::REG_PERIOD),
                    setting_value(bod_pkg::REG_LENGTH),
                    setting_value(bod_pkg::REG_REL),
                    setting_value(bod_pkg::REG_MIN));
      per = (gen_per == 0) ? 1 : gen_per;
      len = (gen_len > per) ? per : gen_len;
      if (len == 0) len = 1;
      span = gen_first + 2 * per + len;
      if (span > 40) n = $urandom_range(1, 12);
      else if ($urandom_range(0, 9) < 7) n = $urandom_range((span > 3) ? span - 2 : 1, span + 4);
      else n = $urandom_range(1, span);
      cut = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
        if (k == cut) begin
          // Change one register in the middle of a capture.
          sel = bod_pkg::reg_index_t'($urandom_range(0, 4));
          push_drain();
          push_cfg(sel, setting_value(sel));
        end
        push_sample(sample_word(), k == n - 1);
        words++;
      end
      captures++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (onsets_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("%0t: timeout with %0d results outstanding", $time, onsets_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
